@@ hdl/particle_motion_fade_step_top_assert.svh @@
// Assertion macros for the particle step block.
`ifndef PARTICLE_MOTION_FADE_STEP_TOP_ASSERT_SVH
`define PARTICLE_MOTION_FADE_STEP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PMFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PMFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pmfs_pkg.sv @@
`default_nettype none
package pmfs_pkg;

    localparam int unsigned DivSteps = 32;
    localparam int unsigned AlphaSteps = 8;
    localparam int unsigned CordicSteps = 16;
    localparam int unsigned LastStage = 35;

    localparam logic signed [19:0] CordicX0 = 20'sd39797;
    localparam logic signed [25:0] PosMax = 26'sd8388607;
    localparam logic signed [25:0] PosMin = -26'sd8388608;
    localparam logic signed [52:0] RoundHalf = 53'sd134217728;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [23:0]        nage;
        logic [7:0]         alpha;
        logic               expired;
        logic               move;
        logic               flip;
        logic [23:0]        life;
    } t_pass;

    function automatic logic signed [20:0] arc_of(input int unsigned i);
        logic signed [20:0] v;
        begin
            unique case (i)
                0:  v = 21'sd131072;
                1:  v = 21'sd77376;
                2:  v = 21'sd40884;
                3:  v = 21'sd20753;
                4:  v = 21'sd10417;
                5:  v = 21'sd5213;
                6:  v = 21'sd2607;
                7:  v = 21'sd1304;
                8:  v = 21'sd652;
                9:  v = 21'sd326;
                10: v = 21'sd163;
                11: v = 21'sd81;
                12: v = 21'sd41;
                13: v = 21'sd20;
                14: v = 21'sd10;
                15: v = 21'sd5;
                default: v = 21'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

@@ hdl/particle_motion_fade_step_top.sv @@
// channel  | handshake                  | beat
// ---------+----------------------------+--------------------------------------------
// input    | i_valid / o_stall          | pos_x pos_y base_speed life_span age
//          |                            | heading alpha_in frame_time
// output   | o_valid / i_stall          | new_pos_x new_pos_y new_age alpha_out expired
//
// One beat per cycle in, one per cycle out, while i_stall does not hold the pipe.
// Depth is set by the 32-step restoring divider for the travelled distance;
// the 16-step CORDIC and the 8-step alpha divider run alongside it.
// Reset is synchronous, active low, and clears the valid bits and the skid slot.
// Output stall freezes the pipe; one input beat lands in a skid slot, so o_stall is registered.
`default_nettype none
module particle_motion_fade_step_top
    import pmfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic [15:0]        i_base_speed,
    input  wire logic [23:0]        i_life_span,
    input  wire logic [23:0]        i_age,
    input  wire logic [15:0]        i_heading,
    input  wire logic [7:0]         i_alpha_in,
    input  wire logic [15:0]        i_frame_time,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [23:0]      o_new_pos_x,
    output logic signed [23:0]      o_new_pos_y,
    output logic [23:0]             o_new_age,
    output logic [7:0]              o_alpha_out,
    output logic                    o_expired
);

    logic w_ce;
    logic w_in_acc;

    // skid slot
    logic               r_sk_v;
    logic signed [23:0] r_sk_px, r_sk_py;
    logic [15:0]        r_sk_spd, r_sk_head, r_sk_dt;
    logic [23:0]        r_sk_life, r_sk_age;
    logic [7:0]         r_sk_alpha;

    logic               w_f_v;
    logic signed [23:0] w_f_px, w_f_py;
    logic [15:0]        w_f_spd, w_f_head, w_f_dt;
    logic [23:0]        w_f_life, w_f_age;
    logic [7:0]         w_f_alpha;

    logic                 r_vld [0:LastStage];
    t_pass                r_pass [0:34];
    logic [31:0]          r_p1;
    logic [23:0]          r_diff;
    logic [32:0]          r_a255;
    logic signed [20:0]   r_z0;
    logic [55:0]          r_rem [1:33];
    logic [31:0]          r_quo [1:33];
    logic signed [19:0]   r_cx [1:33];
    logic signed [19:0]   r_cy [1:33];
    logic signed [20:0]   r_cz [1:17];
    logic [32:0]          r_ar [1:9];
    logic [7:0]           r_aq [1:33];
    logic signed [52:0]   r_mx, r_my;

    logic [31:0]        n_p1;
    logic [24:0]        n_sum;
    logic [23:0]        n_nage;
    logic signed [16:0] n_zf;
    logic               n_flip;
    t_pass              n_pass;
    t_pass              n_last;

    assign w_ce     = !(o_valid && i_stall);
    assign o_stall  = r_sk_v;
    assign w_in_acc = i_valid && !r_sk_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (w_ce) begin
            r_sk_v <= 1'b0;
        end else if (w_in_acc) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_ce && w_in_acc) begin
            r_sk_px    <= i_pos_x;
            r_sk_py    <= i_pos_y;
            r_sk_spd   <= i_base_speed;
            r_sk_life  <= i_life_span;
            r_sk_age   <= i_age;
            r_sk_head  <= i_heading;
            r_sk_alpha <= i_alpha_in;
            r_sk_dt    <= i_frame_time;
        end
    end

    always_comb begin
        w_f_v     = r_sk_v || w_in_acc;
        w_f_px    = r_sk_v ? r_sk_px    : i_pos_x;
        w_f_py    = r_sk_v ? r_sk_py    : i_pos_y;
        w_f_spd   = r_sk_v ? r_sk_spd   : i_base_speed;
        w_f_life  = r_sk_v ? r_sk_life  : i_life_span;
        w_f_age   = r_sk_v ? r_sk_age   : i_age;
        w_f_head  = r_sk_v ? r_sk_head  : i_heading;
        w_f_alpha = r_sk_v ? r_sk_alpha : i_alpha_in;
        w_f_dt    = r_sk_v ? r_sk_dt    : i_frame_time;
    end

    // stage 0: age, flags, heading fold, first products
    always_comb begin
        n_p1   = 32'(w_f_spd) * 32'(w_f_dt);
        n_sum  = 25'(w_f_age) + 25'(w_f_dt);
        n_nage = n_sum[24] ? 24'hFFFFFF : n_sum[23:0];
        if (w_f_head >= 16'd16384 && w_f_head < 16'd49152) begin
            n_zf   = $signed({1'b0, w_f_head}) - 17'sd32768;
            n_flip = 1'b1;
        end else if (w_f_head >= 16'd49152) begin
            n_zf   = $signed({1'b1, w_f_head});
            n_flip = 1'b0;
        end else begin
            n_zf   = $signed({1'b0, w_f_head});
            n_flip = 1'b0;
        end
        n_pass.px      = w_f_px;
        n_pass.py      = w_f_py;
        n_pass.nage    = n_nage;
        n_pass.alpha   = w_f_alpha;
        n_pass.expired = n_nage > w_f_life;
        n_pass.move    = (w_f_life != 24'd0) && (w_f_age < w_f_life) && (w_f_spd != 16'd0);
        n_pass.flip    = n_flip;
        n_pass.life    = w_f_life;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LastStage; s++) r_vld[s] <= 1'b0;
        end else if (w_ce) begin
            r_vld[0] <= w_f_v;
            for (int s = 1; s <= LastStage; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_pass[0] <= n_pass;
            r_p1      <= n_p1;
            r_diff    <= w_f_life - w_f_age;
            r_a255    <= 33'(w_f_age) * 33'd255 + 33'(w_f_life) - 33'd1;
            r_z0      <= {n_zf, 4'b0000};
            // stage 1
            r_pass[1] <= r_pass[0];
            r_rem[1]  <= 56'(r_p1) * 56'(r_diff);
            r_quo[1]  <= '0;
            r_cx[1]   <= CordicX0;
            r_cy[1]   <= '0;
            r_cz[1]   <= r_z0;
            r_ar[1]   <= r_a255;
            r_aq[1]   <= '0;
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        localparam int S = k + 2;
        logic [55:0] w_sh;
        logic        w_ge;
        assign w_sh = 56'(r_pass[S-1].life) << (DivSteps - 1 - k);
        assign w_ge = r_rem[S-1] >= w_sh;
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_pass[S] <= r_pass[S-1];
                r_rem[S]  <= w_ge ? r_rem[S-1] - w_sh : r_rem[S-1];
                r_quo[S]  <= {r_quo[S-1][30:0], w_ge};
            end
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_alpha
        localparam int S = k + 2;
        if (k < AlphaSteps) begin : g_step
            logic [32:0] w_sh;
            logic        w_ge;
            assign w_sh = 33'(r_pass[S-1].life) << (AlphaSteps - 1 - k);
            assign w_ge = r_ar[S-1] >= w_sh;
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_ar[S] <= w_ge ? r_ar[S-1] - w_sh : r_ar[S-1];
                    r_aq[S] <= {r_aq[S-1][6:0], w_ge};
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                if (w_ce) r_aq[S] <= r_aq[S-1];
            end
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_cordic
        localparam int S = k + 2;
        if (k < CordicSteps) begin : g_step
            logic signed [19:0] w_xs, w_ys;
            assign w_xs = r_cx[S-1] >>> k;
            assign w_ys = r_cy[S-1] >>> k;
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    if (!r_cz[S-1][20]) begin
                        r_cx[S] <= r_cx[S-1] - w_ys;
                        r_cy[S] <= r_cy[S-1] + w_xs;
                        r_cz[S] <= r_cz[S-1] - arc_of(k);
                    end else begin
                        r_cx[S] <= r_cx[S-1] + w_ys;
                        r_cy[S] <= r_cy[S-1] - w_xs;
                        r_cz[S] <= r_cz[S-1] + arc_of(k);
                    end
                end
            end
        end else if (k == CordicSteps) begin : g_flip
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_cx[S] <= r_pass[S-1].flip ? -r_cx[S-1] : r_cx[S-1];
                    r_cy[S] <= r_pass[S-1].flip ? -r_cy[S-1] : r_cy[S-1];
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_cx[S] <= r_cx[S-1];
                    r_cy[S] <= r_cy[S-1];
                end
            end
        end
    end

    always_comb begin
        n_last = r_pass[33];
        if (r_pass[33].move) n_last.alpha = ~r_aq[33];
    end

    // stage 34: scale unit vector by distance
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_mx      <= r_cx[33] * $signed({1'b0, r_quo[33]});
            r_my      <= r_cy[33] * $signed({1'b0, r_quo[33]});
            r_pass[34] <= n_last;
        end
    end

    // stage 35: round, add to x and subtract from y, saturate
    logic signed [52:0] w_rx, w_ry;
    logic signed [25:0] w_sx, w_sy;
    always_comb begin
        w_rx = r_mx + RoundHalf;
        w_ry = r_my + RoundHalf;
        w_sx = 26'(r_pass[34].px) + 26'($signed(w_rx[52:28]));
        w_sy = 26'(r_pass[34].py) - 26'($signed(w_ry[52:28]));
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            if (!r_pass[34].move) begin
                o_new_pos_x <= r_pass[34].px;
                o_new_pos_y <= r_pass[34].py;
            end else begin
                o_new_pos_x <= (w_sx > PosMax) ? 24'sh7FFFFF :
                               (w_sx < PosMin) ? 24'sh800000 : w_sx[23:0];
                o_new_pos_y <= (w_sy > PosMax) ? 24'sh7FFFFF :
                               (w_sy < PosMin) ? 24'sh800000 : w_sy[23:0];
            end
            o_new_age   <= r_pass[34].nage;
            o_alpha_out <= r_pass[34].alpha;
            o_expired   <= r_pass[34].expired;
        end
    end

    assign o_valid = r_vld[LastStage];

endmodule
`default_nettype wire

@@ hdl/pmfs_chk.sv @@
`default_nettype none
`include "particle_motion_fade_step_top_assert.svh"
module pmfs_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [23:0] o_new_age,
    input wire logic [23:0] o_new_pos_x,
    input wire logic        o_expired
);

    `PMFS_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_new_age) && $stable(o_new_pos_x), "stalled beat changed")
    `PMFS_ASSERT_IMP(a_skid_cause, $rose(o_stall), $past(i_stall) && $past(i_valid), "skid filled without output stall")
    `PMFS_ASSERT_NXT(a_skid_drain, o_stall && !i_stall, !o_stall, "skid slot not drained")
    `PMFS_ASSERT_IMP(a_zero_age, o_valid && o_new_age == 24'd0, !o_expired, "expired with zero age")

endmodule

bind particle_motion_fade_step_top pmfs_chk u_chk (.*);
`default_nettype wire

@@ tb/sv/particle_motion_fade_step_top_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module particle_motion_fade_step_top_tb;
    import pmfs_pkg::*;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [15:0]        spd;
        logic [23:0]        life;
        logic [23:0]        age;
        logic [15:0]        head;
        logic [7:0]         alpha;
        logic [15:0]        dt;
    } t_particle;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [23:0]        nage;
        logic [7:0]         alpha;
        logic               expired;
    } t_step;

    class step_scoreboard;
        t_step pending[$];
        int    errors = 0;

        static function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        static function void heading_vector(logic [15:0] h, output longint c,
                                            output longint s);
            longint z, x, y, xs, ys;
            bit flip;
            longint arcs[16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
                                 1304, 652, 326, 163, 81, 41, 20, 10, 5};
            x = 39797;
            y = 0;
            flip = 0;
            if (h >= 16384 && h < 49152) begin
                z = longint'(h) - 32768;
                flip = 1;
            end else if (h >= 49152) begin
                z = longint'(h) - 65536;
            end else begin
                z = longint'(h);
            end
            z = z * 16;
            for (int i = 0; i < 16; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= arcs[i];
                end else begin
                    x += ys;
                    y -= xs;
                    z += arcs[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        static function longint clamp_pos(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void note_particle(t_particle p);
            t_step  r;
            longint px, py, nage, q, c, s, dx, dy, life, age;
            px = p.px;
            py = p.py;
            life = p.life;
            age = p.age;
            nage = age + p.dt;
            if (nage > 24'hFFFFFF) nage = 24'hFFFFFF;
            r.alpha = p.alpha;
            if (life > 0 && age < life && p.spd > 0) begin
                q = (longint'(p.dt) * p.spd * (life - age)) / life;
                heading_vector(p.head, c, s);
                dx = fshift(c * q + (longint'(1) << 27), 28);
                dy = fshift(s * q + (longint'(1) << 27), 28);
                px = clamp_pos(px + dx);
                py = clamp_pos(py - dy);
                r.alpha = 8'(255 - (255 * age + life - 1) / life);
            end
            r.px = px[23:0];
            r.py = py[23:0];
            r.nage = nage[23:0];
            r.expired = nage > life;
            pending.push_back(r);
        endfunction

        function void check_step(t_step got);
            t_step e;
            if (pending.size() == 0) begin
                $error("unexpected output beat");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.px !== e.px) begin
                $error("new_pos_x exp %0d got %0d", e.px, got.px); errors++;
            end
            if (got.py !== e.py) begin
                $error("new_pos_y exp %0d got %0d", e.py, got.py); errors++;
            end
            if (got.nage !== e.nage) begin
                $error("new_age exp %0d got %0d", e.nage, got.nage); errors++;
            end
            if (got.alpha !== e.alpha) begin
                $error("alpha_out exp %0d got %0d", e.alpha, got.alpha); errors++;
            end
            if (got.expired !== e.expired) begin
                $error("expired exp %0d got %0d", e.expired, got.expired); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic o_stall, o_valid, o_expired;
    logic signed [23:0] i_pos_x = 0, i_pos_y = 0, o_new_pos_x, o_new_pos_y;
    logic [15:0] i_base_speed = 0, i_heading = 0, i_frame_time = 0;
    logic [23:0] i_life_span = 0, i_age = 0, o_new_age;
    logic [7:0]  i_alpha_in = 0, o_alpha_out;

    particle_motion_fade_step_top dut (.*);

    step_scoreboard sb = new();
    int send_idle = 0, recv_idle = 0, hold_cycles = 0;
    t_particle cur;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_particle(cur);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_step('{o_new_pos_x, o_new_pos_y, o_new_age, o_alpha_out, o_expired});
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_particle(t_particle p);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        cur = p;
        i_valid <= 1;
        i_pos_x <= p.px;
        i_pos_y <= p.py;
        i_base_speed <= p.spd;
        i_life_span <= p.life;
        i_age <= p.age;
        i_heading <= p.head;
        i_alpha_in <= p.alpha;
        i_frame_time <= p.dt;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic t_particle rand_particle();
        t_particle p;
        p.px = 24'($urandom);
        p.py = 24'($urandom);
        p.spd = 16'($urandom);
        p.head = 16'($urandom);
        p.alpha = 8'($urandom);
        p.dt = 16'($urandom);
        p.life = 24'($urandom);
        case ($urandom_range(9))
            0: p.age = 24'(p.life + $urandom_range(1000));
            1: p.life = 0;
            2: p.spd = 0;
            3: begin p.px = 24'(24'h7FFF00 + $urandom_range(255)); p.spd = 16'hFFFF; end
            4: p.age = 24'(24'hFFFFFF - $urandom_range(3000));
            default: p.age = 24'((longint'(p.life) * $urandom_range(1000)) / 1001);
        endcase
        if ($urandom_range(3) == 0) p.life = 24'($urandom_range(200));
        return p;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        send_particle('{24'sh7FFFFF, 24'sh800000, 16'hFFFF, 24'hFFFFFF, 0, 0, 8'hFF, 16'hFFFF});
        send_particle('{24'sh800000, 24'sh7FFFFF, 16'hFFFF, 24'hFFFFFF, 0, 16'h8000, 0, 16'hFFFF});
        send_particle('{0, 0, 16'hFFFF, 1, 0, 16'h4000, 8'h55, 16'hFFFF});
        send_particle('{0, 0, 16'hFFFF, 1, 0, 16'hC000, 8'h55, 16'hFFFF});
        send_particle('{0, 0, 100, 0, 0, 16'h1234, 8'h40, 100});
        send_particle('{0, 0, 100, 0, 0, 0, 8'h40, 0});
        send_particle('{5, 5, 100, 1000, 1000, 0, 8'h22, 10});
        send_particle('{5, 5, 0, 1000, 10, 0, 8'h22, 10});
        send_particle('{0, 0, 100, 24'hFFFFFF, 24'hFFFFF0, 16'h3FFF, 8'h11, 16'hFFFF});
        send_particle('{24'sh7FFF00, 24'sh800100, 16'hFFFF, 24'hFFFFFF, 0, 16'hE000, 1, 16'hFFFF});
        send_particle('{0, 0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFE, 16'h2000, 0, 16'hFFFF});
        send_particle('{0, 0, 1, 24'hFFFFFF, 0, 16'hFFFF, 0, 1});
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_idle = 0; end
                1: begin send_idle = 80; recv_idle = 0; end
                2: begin send_idle = 0; recv_idle = 80; end
                3: begin send_idle = 18; recv_idle = 18; end
                4: begin send_idle = 0; recv_idle = 0; hold_cycles = 200; end
            endcase
            repeat (350) send_particle(rand_particle());
        end
        i_valid <= 0;
        send_idle = 0; recv_idle = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ particle_motion_fade_step_top.f @@
+incdir+hdl
hdl/pmfs_pkg.sv
hdl/particle_motion_fade_step_top.sv
hdl/pmfs_chk.sv
tb/sv/particle_motion_fade_step_top_tb.sv
